// File: hw/rtl/cpt_pkg.sv
package cpt_pkg;

    typedef enum logic [2:0] {
        REGION_VERTEX_A = 3'd0,
        REGION_VERTEX_B = 3'd1,
        REGION_EDGE_AB  = 3'd2,
        REGION_VERTEX_C = 3'd3,
        REGION_EDGE_AC  = 3'd4,
        REGION_EDGE_BC  = 3'd5,
        REGION_INTERIOR = 3'd6
    } region_t;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 66;
    localparam int DOT_W   = 68;
    localparam int DET_W   = 136;
    localparam int DIV_W   = 140;
    localparam int SUM_W   = 36;

    typedef logic [2:0][COORD_W-1:0] vec3_t;
    typedef logic [2:0][DIFF_W-1:0]  dvec3_t;

    typedef struct packed {
        vec3_t  a;
        vec3_t  b;
        vec3_t  c;
        dvec3_t ab;
        dvec3_t ac;
        dvec3_t bc;
    } geo_t;

    typedef struct packed {
        vec3_t   base;
        dvec3_t  e0;
        dvec3_t  e1;
        region_t region;
        logic    degen;
    } pick_t;

endpackage

// File: hw/rtl/cpt_mul.sv
module cpt_mul #(
    parameter int W = 68
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    localparam int H  = W / 2;
    localparam int L  = W - H;
    localparam int PW = 2 * W;

    logic signed [2*L-1:0] hh_reg;
    logic signed [L+H:0]   hl_reg;
    logic signed [L+H:0]   lh_reg;
    logic        [2*H-1:0] ll_reg;
    logic signed [PW-1:0]  p_reg;

    always_ff @(posedge clk)
    begin
        hh_reg <= $signed(a[W-1:H]) * $signed(b[W-1:H]);
        hl_reg <= $signed(a[W-1:H]) * $signed({1'b0, b[H-1:0]});
        lh_reg <= $signed({1'b0, a[H-1:0]}) * $signed(b[W-1:H]);
        ll_reg <= a[H-1:0] * b[H-1:0];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= (PW'(hh_reg) <<< (2 * H)) + ((PW'(hl_reg) + PW'(lh_reg)) <<< H)
               + PW'({1'b0, ll_reg});
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/cpt_div.sv
module cpt_div #(
    parameter int W    = 140,
    parameter int FRAC = 16
) (
    input  logic                clk,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic        [FRAC:0] q
);

    localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

    logic signed [W-1:0] n_abs;
    logic signed [W-1:0] d_abs;
    logic                pre_done;
    logic [FRAC:0]       pre_q;

    logic signed [W-1:0] n_reg    [FRAC+1];
    logic signed [W-1:0] d_reg    [FRAC+1];
    logic [FRAC:0]       q_reg    [FRAC+1];
    logic                done_reg [FRAC+1];

    always_comb
    begin
        n_abs    = (den < 0) ? -num : num;
        d_abs    = (den < 0) ? -den : den;
        pre_done = 1'b1;
        pre_q    = '0;
        if (den == 0)
        begin
            pre_q = '0;
        end
        else if (n_abs <= 0)
        begin
            pre_q = '0;
        end
        else if (n_abs >= d_abs)
        begin
            pre_q = ONE;
        end
        else
        begin
            pre_done = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0]    <= n_abs;
        d_reg[0]    <= d_abs;
        q_reg[0]    <= pre_q;
        done_reg[0] <= pre_done;
    end

    for (genvar k = 1; k <= FRAC; k++)
    begin : g_step
        logic signed [W-1:0] n2;
        logic signed [W-1:0] diff;

        assign n2   = n_reg[k-1] <<< 1;
        assign diff = n2 - d_reg[k-1];

        always_ff @(posedge clk)
        begin
            d_reg[k]    <= d_reg[k-1];
            done_reg[k] <= done_reg[k-1];
            if (done_reg[k-1])
            begin
                n_reg[k] <= n_reg[k-1];
                q_reg[k] <= q_reg[k-1];
            end
            else if (diff >= 0)
            begin
                n_reg[k] <= diff;
                q_reg[k] <= {q_reg[k-1][FRAC-1:0], 1'b1};
            end
            else
            begin
                n_reg[k] <= n2;
                q_reg[k] <= {q_reg[k-1][FRAC-1:0], 1'b0};
            end
        end
    end

    assign q = q_reg[FRAC];

endmodule

// File: hw/rtl/closest_point_on_triangle.sv
// Closest point on a triangle to a query point, fully pipelined.
// Input channel: a beat of vertices a, b, c and the query point (signed
// Q16.16 per coordinate) is taken at a rising edge with start high and
// busy low. busy is always low: a new beat may enter every cycle.
// Output channel: done is high for exactly one cycle with closest_x/y/z,
// region and degenerate; the receiver takes the result in that cycle.
// Throughput: one beat per cycle. The depth is set by the restoring weight
// dividers, one quotient bit per stage, after seven stages of differences,
// dot products, split 68x68 determinant multipliers and region tests, and
// two final stages that scale the edge vectors and saturate the sum.
// Results leave in the order the beats were taken.
// Reset clears all valid bits at once; beats in flight are dropped and no
// done pulse follows for them. The receiver cannot stall the pipeline.
module closest_point_on_triangle #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] query_z,
    output logic               done,
    output logic signed [31:0] closest_x,
    output logic signed [31:0] closest_y,
    output logic signed [31:0] closest_z,
    output logic [2:0]         region,
    output logic               degenerate
);

    localparam int LAT   = FRAC_BITS + 10;
    localparam int CW    = cpt_pkg::COORD_W;
    localparam int DW    = cpt_pkg::DIFF_W;
    localparam int PRW   = cpt_pkg::PROD_W;
    localparam int DOTW  = cpt_pkg::DOT_W;
    localparam int DETW  = cpt_pkg::DET_W;
    localparam int DIVW  = cpt_pkg::DIV_W;
    localparam int SUMW  = cpt_pkg::SUM_W;
    localparam int SW    = DETW + 1;
    localparam int WTW   = FRAC_BITS + 1;
    localparam int SPW   = DW + WTW + 1;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic             accept;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   vld_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: differences
    cpt_pkg::vec3_t  in_a, in_b, in_c, in_q;
    cpt_pkg::geo_t   geo_in;
    cpt_pkg::dvec3_t ap_in, bp_in, cp_in;

    assign in_a = {a_z, a_y, a_x};
    assign in_b = {b_z, b_y, b_x};
    assign in_c = {c_z, c_y, c_x};
    assign in_q = {query_z, query_y, query_x};

    always_comb
    begin
        geo_in.a = in_a;
        geo_in.b = in_b;
        geo_in.c = in_c;
        for (int k = 0; k < 3; k++)
        begin
            geo_in.ab[k] = DW'($signed(in_b[k])) - DW'($signed(in_a[k]));
            geo_in.ac[k] = DW'($signed(in_c[k])) - DW'($signed(in_a[k]));
            geo_in.bc[k] = DW'($signed(in_c[k])) - DW'($signed(in_b[k]));
            ap_in[k]     = DW'($signed(in_q[k])) - DW'($signed(in_a[k]));
            bp_in[k]     = DW'($signed(in_q[k])) - DW'($signed(in_b[k]));
            cp_in[k]     = DW'($signed(in_q[k])) - DW'($signed(in_c[k]));
        end
    end

    cpt_pkg::geo_t   geo1_reg, geo2_reg, geo3_reg, geo4_reg, geo5_reg, geo6_reg;
    cpt_pkg::dvec3_t ap1_reg, bp1_reg, cp1_reg;

    always_ff @(posedge clk)
    begin
        geo1_reg <= geo_in;
        ap1_reg  <= ap_in;
        bp1_reg  <= bp_in;
        cp1_reg  <= cp_in;
    end

    // stage 2: component products
    cpt_pkg::dvec3_t lhs [6];
    cpt_pkg::dvec3_t rhs [6];
    logic signed [PRW-1:0] prod2_reg [6][3];

    always_comb
    begin
        lhs[0] = geo1_reg.ab; rhs[0] = ap1_reg;
        lhs[1] = geo1_reg.ac; rhs[1] = ap1_reg;
        lhs[2] = geo1_reg.ab; rhs[2] = bp1_reg;
        lhs[3] = geo1_reg.ac; rhs[3] = bp1_reg;
        lhs[4] = geo1_reg.ab; rhs[4] = cp1_reg;
        lhs[5] = geo1_reg.ac; rhs[5] = cp1_reg;
    end

    always_ff @(posedge clk)
    begin
        geo2_reg <= geo1_reg;
        for (int j = 0; j < 6; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod2_reg[j][k] <= $signed(lhs[j][k]) * $signed(rhs[j][k]);
            end
        end
    end

    // stage 3: dot products d1..d6
    logic signed [DOTW-1:0] dot3_reg [6];
    logic signed [DOTW-1:0] dot4_reg [6];
    logic signed [DOTW-1:0] dot5_reg [6];
    logic signed [DOTW-1:0] dot6_reg [6];

    always_ff @(posedge clk)
    begin
        geo3_reg <= geo2_reg;
        for (int j = 0; j < 6; j++)
        begin
            dot3_reg[j] <= DOTW'(prod2_reg[j][0]) + DOTW'(prod2_reg[j][1])
                         + DOTW'(prod2_reg[j][2]);
        end
    end

    // stages 4 and 5: determinant products
    logic signed [2*DOTW-1:0] mp [6];

    cpt_mul #(.W(DOTW)) u_mul0 (.clk(clk), .a(dot3_reg[0]), .b(dot3_reg[3]), .p(mp[0]));
    cpt_mul #(.W(DOTW)) u_mul1 (.clk(clk), .a(dot3_reg[2]), .b(dot3_reg[1]), .p(mp[1]));
    cpt_mul #(.W(DOTW)) u_mul2 (.clk(clk), .a(dot3_reg[4]), .b(dot3_reg[1]), .p(mp[2]));
    cpt_mul #(.W(DOTW)) u_mul3 (.clk(clk), .a(dot3_reg[0]), .b(dot3_reg[5]), .p(mp[3]));
    cpt_mul #(.W(DOTW)) u_mul4 (.clk(clk), .a(dot3_reg[2]), .b(dot3_reg[5]), .p(mp[4]));
    cpt_mul #(.W(DOTW)) u_mul5 (.clk(clk), .a(dot3_reg[4]), .b(dot3_reg[3]), .p(mp[5]));

    always_ff @(posedge clk)
    begin
        geo4_reg <= geo3_reg;
        geo5_reg <= geo4_reg;
        geo6_reg <= geo5_reg;
        dot4_reg <= dot3_reg;
        dot5_reg <= dot4_reg;
        dot6_reg <= dot5_reg;
    end

    // stage 6: determinants and edge terms
    logic signed [DETW-1:0] va6_reg, vb6_reg, vc6_reg;
    logic signed [DOTW:0]   e1_6_reg, e2_6_reg;

    always_ff @(posedge clk)
    begin
        vc6_reg  <= DETW'(mp[0]) - DETW'(mp[1]);
        vb6_reg  <= DETW'(mp[2]) - DETW'(mp[3]);
        va6_reg  <= DETW'(mp[4]) - DETW'(mp[5]);
        e1_6_reg <= (DOTW+1)'(dot5_reg[3]) - (DOTW+1)'(dot5_reg[2]);
        e2_6_reg <= (DOTW+1)'(dot5_reg[4]) - (DOTW+1)'(dot5_reg[5]);
    end

    // stage 7: region tests and divider operands
    logic signed [DOTW-1:0] d1, d2, d3, d6;
    logic signed [SW-1:0]   ssum;
    logic signed [DIVW-1:0] num0, den0, num1, den1;
    cpt_pkg::pick_t         pick;

    assign d1 = dot6_reg[0];
    assign d2 = dot6_reg[1];
    assign d3 = dot6_reg[2];
    assign d6 = dot6_reg[5];

    always_comb
    begin
        ssum        = SW'(va6_reg) + SW'(vb6_reg) + SW'(vc6_reg);
        num0        = '0;
        den0        = '0;
        num1        = '0;
        den1        = '0;
        pick.base   = geo6_reg.a;
        pick.e0     = geo6_reg.ab;
        pick.e1     = geo6_reg.ac;
        pick.degen  = 1'b0;
        pick.region = cpt_pkg::REGION_INTERIOR;
        if (d1 <= 0 && d2 <= 0)
        begin
            pick.region = cpt_pkg::REGION_VERTEX_A;
        end
        else if (d3 >= 0 && e1_6_reg <= 0)
        begin
            pick.region = cpt_pkg::REGION_VERTEX_B;
            pick.base   = geo6_reg.b;
        end
        else if (vc6_reg <= 0 && d1 >= 0 && d3 <= 0)
        begin
            pick.region = cpt_pkg::REGION_EDGE_AB;
            num0        = DIVW'(d1);
            den0        = DIVW'(d1) - DIVW'(d3);
        end
        else if (d6 >= 0 && e2_6_reg <= 0)
        begin
            pick.region = cpt_pkg::REGION_VERTEX_C;
            pick.base   = geo6_reg.c;
        end
        else if (vb6_reg <= 0 && d2 >= 0 && d6 <= 0)
        begin
            pick.region = cpt_pkg::REGION_EDGE_AC;
            pick.e0     = geo6_reg.ac;
            num0        = DIVW'(d2);
            den0        = DIVW'(d2) - DIVW'(d6);
        end
        else if (va6_reg <= 0 && e1_6_reg >= 0 && e2_6_reg >= 0)
        begin
            pick.region = cpt_pkg::REGION_EDGE_BC;
            pick.base   = geo6_reg.b;
            pick.e0     = geo6_reg.bc;
            num0        = DIVW'(e1_6_reg);
            den0        = DIVW'(e1_6_reg) + DIVW'(e2_6_reg);
        end
        else
        begin
            pick.degen = (ssum == 0);
            num0       = DIVW'(vb6_reg);
            den0       = DIVW'(ssum);
            num1       = DIVW'(vc6_reg);
            den1       = DIVW'(ssum);
        end
    end

    logic signed [DIVW-1:0] num0_reg, den0_reg, num1_reg, den1_reg;
    cpt_pkg::pick_t         pick_reg [FRAC_BITS+2];

    always_ff @(posedge clk)
    begin
        num0_reg    <= num0;
        den0_reg    <= den0;
        num1_reg    <= num1;
        den1_reg    <= den1;
        pick_reg[0] <= pick;
        for (int k = 1; k < FRAC_BITS + 2; k++)
        begin
            pick_reg[k] <= pick_reg[k-1];
        end
    end

    // stages 8 .. FRAC_BITS+8: weights
    logic [WTW-1:0] w0, w1;

    cpt_div #(.W(DIVW), .FRAC(FRAC_BITS)) u_div0 (
        .clk(clk), .num(num0_reg), .den(den0_reg), .q(w0)
    );

    cpt_div #(.W(DIVW), .FRAC(FRAC_BITS)) u_div1 (
        .clk(clk), .num(num1_reg), .den(den1_reg), .q(w1)
    );

    // stage FRAC_BITS+9: scale edge vectors
    logic signed [SPW-1:0] sp0_reg [3];
    logic signed [SPW-1:0] sp1_reg [3];
    cpt_pkg::pick_t        pick_s_reg;
    cpt_pkg::pick_t        pick_w;

    assign pick_w = pick_reg[FRAC_BITS+1];

    always_ff @(posedge clk)
    begin
        pick_s_reg <= pick_w;
        for (int k = 0; k < 3; k++)
        begin
            sp0_reg[k] <= $signed(pick_w.e0[k]) * $signed({1'b0, w0});
            sp1_reg[k] <= $signed(pick_w.e1[k]) * $signed({1'b0, w1});
        end
    end

    // stage FRAC_BITS+10: sum and saturate
    logic signed [SUMW-1:0] sum    [3];
    logic        [CW-1:0]   sat    [3];
    logic        [CW-1:0]   out_reg [3];
    logic                   degen_reg;
    cpt_pkg::region_t       region_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SUMW'($signed(pick_s_reg.base[k]))
                   + SUMW'(sp0_reg[k] >>> FRAC_BITS)
                   + SUMW'(sp1_reg[k] >>> FRAC_BITS);
            if (&sum[k][SUMW-1:CW-1] || !(|sum[k][SUMW-1:CW-1]))
            begin
                sat[k] = sum[k][CW-1:0];
            end
            else if (sum[k][SUMW-1])
            begin
                sat[k] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                sat[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= sat;
        region_reg <= pick_s_reg.region;
        degen_reg  <= pick_s_reg.degen;
    end

    assign done       = vld_reg[LAT-1];
    assign closest_x  = out_reg[0];
    assign closest_y  = out_reg[1];
    assign closest_z  = out_reg[2];
    assign region     = region_reg;
    assign degenerate = degen_reg;

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LAT) done)
        else $error("accepted beat did not come out after the pipeline latency");

    a_degen_interior : assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> region == cpt_pkg::REGION_INTERIOR)
        else $error("degenerate flag outside the interior region");

    a_weight_range : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRAC_BITS+7] |-> (w0 <= ONE) && (w1 <= ONE))
        else $error("weight above one");

    a_vertex_weight : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FRAC_BITS+7] && (pick_w.region == cpt_pkg::REGION_VERTEX_A
            || pick_w.region == cpt_pkg::REGION_VERTEX_B
            || pick_w.region == cpt_pkg::REGION_VERTEX_C)
        |-> (w0 == 0) && (w1 == 0))
        else $error("vertex region with nonzero weight");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        cpt_pkg::region_t reg_id;
        logic             degen;
    } point_t;

    typedef struct {
        logic [0:11][31:0] crd;
        bit                typed;
        point_t            want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [31:0] c_x = '0, c_y = '0, c_z = '0;
    logic signed [31:0] query_x = '0, query_y = '0, query_z = '0;
    logic done;
    logic signed [31:0] closest_x, closest_y, closest_z;
    logic [2:0] region;
    logic degenerate;

    bit     beat_typed = 1'b0;
    point_t beat_want;
    point_t pending_q[$];
    row_t   rows[$];
    int     errors = 0;
    int     cycles = 0;

    closest_point_on_triangle #(.FRAC_BITS(FRAC)) i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic wide_t dot3(input longint u[3], input longint v[3]);
        wide_t s;
        s = '0;
        for (int k = 0; k < 3; k++)
            s = s + wide_t'(u[k]) * wide_t'(v[k]);
        return s;
    endfunction

    function automatic logic [31:0] frac_weight(input wide_t num, input wide_t den);
        wide_t n;
        wide_t d;
        n = num;
        d = den;
        if (d == 0)
            return '0;
        if (d < 0)
        begin
            d = -d;
            n = -n;
        end
        if (n <= 0)
            return '0;
        if (n >= d)
            return 32'd1 << FRAC;
        return 32'((n <<< FRAC) / d);
    endfunction

    function automatic longint along(input longint e, input logic [31:0] t);
        longint p;
        p = e * longint'({32'd0, t});
        return p >>> FRAC;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic point_t closest_point(input logic [0:11][31:0] crd);
        longint pa[3], pb[3], pc[3], pq[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        longint res[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, s;
        logic [31:0] t, t2;
        point_t r;
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = longint'(signed'(crd[k]));
            pb[k] = longint'(signed'(crd[3 + k]));
            pc[k] = longint'(signed'(crd[6 + k]));
            pq[k] = longint'(signed'(crd[9 + k]));
            ab[k] = pb[k] - pa[k];
            ac[k] = pc[k] - pa[k];
            bc[k] = pc[k] - pb[k];
            ap[k] = pq[k] - pa[k];
            bp[k] = pq[k] - pb[k];
            cp[k] = pq[k] - pc[k];
        end
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        r.degen = 1'b0;
        if (d1 <= 0 && d2 <= 0)
        begin
            r.reg_id = cpt_pkg::REGION_VERTEX_A;
            res = pa;
        end
        else if (d3 >= 0 && e1 <= 0)
        begin
            r.reg_id = cpt_pkg::REGION_VERTEX_B;
            res = pb;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            r.reg_id = cpt_pkg::REGION_EDGE_AB;
            t = frac_weight(d1, d1 - d3);
            for (int k = 0; k < 3; k++)
                res[k] = pa[k] + along(ab[k], t);
        end
        else if (d6 >= 0 && d5 - d6 <= 0)
        begin
            r.reg_id = cpt_pkg::REGION_VERTEX_C;
            res = pc;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            r.reg_id = cpt_pkg::REGION_EDGE_AC;
            t = frac_weight(d2, d2 - d6);
            for (int k = 0; k < 3; k++)
                res[k] = pa[k] + along(ac[k], t);
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            r.reg_id = cpt_pkg::REGION_EDGE_BC;
            t = frac_weight(e1, e1 + e2);
            for (int k = 0; k < 3; k++)
                res[k] = pb[k] + along(bc[k], t);
        end
        else
        begin
            r.reg_id = cpt_pkg::REGION_INTERIOR;
            s = va + vb + vc;
            if (s == 0)
            begin
                r.degen = 1'b1;
                res = pa;
            end
            else
            begin
                t = frac_weight(vb, s);
                t2 = frac_weight(vc, s);
                for (int k = 0; k < 3; k++)
                    res[k] = pa[k] + along(ab[k], t) + along(ac[k], t2);
            end
        end
        r.x = clamp32(res[0]);
        r.y = clamp32(res[1]);
        r.z = clamp32(res[2]);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    // check results, then record the beat taken at this edge
    always @(posedge clk)
    begin
        point_t w;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing pending", $time);
                errors++;
            end
            else
            begin
                w = pending_q.pop_front();
                if (closest_x !== w.x) report_mismatch("closest_x", closest_x, w.x);
                if (closest_y !== w.y) report_mismatch("closest_y", closest_y, w.y);
                if (closest_z !== w.z) report_mismatch("closest_z", closest_z, w.z);
                if (region !== w.reg_id) report_mismatch("region", region, w.reg_id);
                if (degenerate !== w.degen)
                    report_mismatch("degenerate", degenerate, w.degen);
            end
        end
        if (rst_n && start && !busy)
        begin
            if (beat_typed)
                pending_q.push_back(beat_want);
            else
                pending_q.push_back(closest_point({a_x, a_y, a_z, b_x, b_y, b_z,
                                                   c_x, c_y, c_z, query_x, query_y, query_z}));
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("closest_point_on_triangle: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input logic [0:11][31:0] crd, input bit typed, input point_t want);
        bit was_busy;
        start   <= 1'b1;
        a_x     <= crd[0];  a_y     <= crd[1];  a_z     <= crd[2];
        b_x     <= crd[3];  b_y     <= crd[4];  b_z     <= crd[5];
        c_x     <= crd[6];  c_y     <= crd[7];  c_z     <= crd[8];
        query_x <= crd[9];  query_y <= crd[10]; query_z <= crd[11];
        beat_typed <= typed;
        beat_want  <= want;
        forever
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
                break;
        end
    endtask

    task automatic add_row(input logic [0:11][31:0] crd, input bit typed, input point_t want);
        row_t r;
        r.crd = crd;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    function automatic logic [31:0] pick_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return ($urandom_range(0, 400) - 200) << FRAC;
            default: return $urandom_range(0, 8) - 4;
        endcase
    endfunction

    function automatic logic [0:11][31:0] random_beat();
        logic [0:11][31:0] crd;
        int mode;
        int kind;
        int m;
        kind = $urandom_range(0, 9);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < 12; i++)
            crd[i] = pick_coord(mode);
        if (kind == 0)
        begin
            // collinear triangle
            m = $urandom_range(0, 4) - 2;
            for (int k = 0; k < 3; k++)
                crd[6 + k] = crd[k] + m * (crd[3 + k] - crd[k]);
        end
        else if (kind == 1)
        begin
            // coincident vertices
            for (int k = 0; k < 3; k++)
                crd[3 + k] = crd[k];
        end
        else if (kind == 2)
        begin
            // query from a mix of the vertices
            for (int k = 0; k < 3; k++)
                crd[9 + k] = (crd[k] >>> 2) + (crd[3 + k] >>> 2) + (crd[6 + k] >>> 1)
                             + pick_coord(2);
        end
        return crd;
    endfunction

    initial
    begin
        localparam logic [31:0] ONE = 32'd1 << FRAC;
        localparam logic [31:0] MAXV = 32'h7fffffff;
        localparam logic [31:0] MINV = 32'h80000000;
        point_t none;
        point_t w;
        logic [0:11][31:0] crd;
        int n_items;

        none = '{x: '0, y: '0, z: '0, reg_id: cpt_pkg::REGION_VERTEX_A, degen: 1'b0};

        w = '{x: '0, y: '0, z: '0, reg_id: cpt_pkg::REGION_VERTEX_A, degen: 1'b0};
        add_row('0, 1'b1, w);
        w = '{x: MAXV, y: MAXV, z: MAXV, reg_id: cpt_pkg::REGION_VERTEX_A, degen: 1'b0};
        add_row({12{MAXV}}, 1'b1, w);
        w = '{x: MINV, y: MINV, z: MINV, reg_id: cpt_pkg::REGION_VERTEX_A, degen: 1'b0};
        add_row({12{MINV}}, 1'b1, w);
        // right triangle in the xy plane: a origin, b on x, c on y
        w = '{x: '0, y: '0, z: '0, reg_id: cpt_pkg::REGION_VERTEX_A, degen: 1'b0};
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 32'd0, 32'd0, 32'd0}, 1'b1, w);
        w = '{x: ONE, y: '0, z: '0, reg_id: cpt_pkg::REGION_VERTEX_B, degen: 1'b0};
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 ONE, 32'd0, 32'd0}, 1'b1, w);
        w = '{x: '0, y: ONE, z: '0, reg_id: cpt_pkg::REGION_VERTEX_C, degen: 1'b0};
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 32'd0, ONE, 32'd0}, 1'b1, w);
        // remaining regions, extremes and degenerate shapes go through the predictor
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 ONE >> 1, -ONE, 32'd0}, 1'b0, none);
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 -ONE, ONE >> 1, ONE}, 1'b0, none);
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 ONE, ONE, -ONE}, 1'b0, none);
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 ONE >> 2, ONE >> 2, ONE}, 1'b0, none);
        add_row({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0,
                 32'd3, 32'd5, MAXV}, 1'b0, none);
        add_row({32'd0, 32'd0, 32'd0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                 ONE, 32'd0, 32'd0}, 1'b0, none);
        add_row({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0,
                 ONE >> 1, ONE, 32'd0}, 1'b0, none);
        add_row({MINV, MINV, MINV, MAXV, MINV, MINV, MINV, MAXV, MINV,
                 MAXV, MAXV, MAXV}, 1'b0, none);
        add_row({MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV, MAXV,
                 MINV, MINV, MINV}, 1'b0, none);
        add_row({MINV, MINV, 32'd0, MAXV, MINV, 32'd0, 32'd0, MAXV, 32'd0,
                 32'd0, 32'd0, MAXV}, 1'b0, none);
        add_row({MAXV, 32'd0, MINV, MINV, MAXV, 32'd0, 32'd0, MINV, MAXV,
                 MINV, MAXV, MINV}, 1'b0, none);
        add_row({32'hffffffff, 32'd1, 32'hffffffff, 32'd1, 32'hffffffff, 32'd1,
                 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                 32'haaaaaaaa, 32'h55555555}, 1'b0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_beat(rows[i].crd, rows[i].typed, rows[i].want);

        n_items = 1800;
        for (int i = 0; i < n_items; i++)
        begin
            crd = random_beat();
            send_beat(crd, 1'b0, none);
            if (i < n_items - 300 && $urandom_range(0, 3) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        start <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (errors == 0 && pending_q.size() == 0)
            $display("closest_point_on_triangle: match");
        else
            $display("closest_point_on_triangle: mismatch");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_mul.sv
hw/rtl/cpt_div.sv
hw/rtl/closest_point_on_triangle.sv
tb/tb.sv
